>>> sv/lpv_pkg.sv
// Shared types, constants and helper functions for the speed-scheduled
// state-space Euler step unit. No dependencies; used by every module of the block.
package lpv_pkg;

    localparam int STATE_COUNT = 2;
    localparam int COEF_WIDTH  = 16;

    // Configuration port
    localparam int CFG_DW = 64;
    localparam int CFG_AW = 6;
    localparam int CFG_IW = 3;
    localparam int GAIN_W = 48;
    localparam int TS_W   = 16;

    localparam logic [CFG_IW-1:0] REG_A_BIAS    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_A_SPEED   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DRIVE_GAIN = 3'd2;
    localparam logic [CFG_IW-1:0] REG_C_WORDS   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_TIME_STEP = 3'd4;

    localparam logic [TS_W-1:0] TIME_STEP_RESET = 16'd655;

    // Datapath widths
    localparam int IN_W     = 16;
    localparam int X_W      = 32;
    localparam int EFF_W    = COEF_WIDTH + 19;
    localparam int MA_W     = EFF_W;
    localparam int MB_W     = 18;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int SUM_W    = 48;
    localparam int PACC_W   = 68;
    localparam int XSUM_W   = 52;
    localparam int DX_SPLIT = 24;
    localparam int X_SPLIT  = 16;
    localparam int IN_FRAC  = 8;
    localparam int EFF_FRAC = 20;
    localparam int GAIN_SHIFT = 4;
    localparam int DT_FRAC  = 16;

    localparam logic [IN_W-1:0] MIN_SPEED = 16'd1280;

    // Group counter: 0 is the output row, 1..STATE_COUNT are the state rows
    localparam int GW = $clog2(STATE_COUNT + 1);
    localparam int JW = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EFF,
        ST_GAP,
        ST_XLO,
        ST_XHI,
        ST_FOLD,
        ST_GAIN,
        ST_SETTLE,
        ST_OUT,
        ST_DLO,
        ST_DHI,
        ST_DGAP,
        ST_DFOLD,
        ST_WRAP,
        ST_COMMIT
    } state_t;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        M_NONE,
        M_EFF,
        M_XLO,
        M_XHI,
        M_GAIN,
        M_DLO,
        M_DHI
    } msel_t;

    // Action taken on the registered product in the cycle after issue
    typedef enum logic [2:0] {
        P_NONE,
        P_EFF,
        P_PLOAD,
        P_PADD16,
        P_PADD24,
        P_FOLD20,
        P_FOLD16,
        P_GAIN
    } post_t;

    typedef struct packed {
        msel_t           msel;
        post_t           post;
        logic [GW-1:0]   grp;
        logic [JW-1:0]   term;
        logic            in_load;
        logic            clr_sum;
        logic            out_load;
        logic            commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    // Signed coefficient field k of a packed word; fields past the word read as zero
    function automatic logic signed [COEF_WIDTH-1:0] coef_field(input logic [63:0] word,
                                                                input int k);
        int          pos;
        logic [63:0] sh;
        pos = k * COEF_WIDTH;
        if (pos >= 64 || pos < 0) begin
            return '0;
        end
        sh = word >> pos;
        return $signed(sh[COEF_WIDTH-1:0]);
    endfunction

    // Saturate to signed X_W bits
    function automatic logic signed [X_W-1:0] sat_x(input logic signed [XSUM_W-1:0] v);
        logic [XSUM_W-X_W:0] top;
        top = v[XSUM_W-1:X_W-1];
        if ((&top) || (~|top)) begin
            return $signed(v[X_W-1:0]);
        end
        if (v[XSUM_W-1]) begin
            return $signed({1'b1, {(X_W-1){1'b0}}});
        end
        return $signed({1'b0, {(X_W-1){1'b1}}});
    endfunction

endpackage

>>> sv/lpv_ctrl.sv
// Sequencer for the Euler step unit: walks the coefficient terms of each row and
// issues at most one multiplier command per cycle, holding while the output register is full. Depends on lpv_pkg.
module lpv_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  lpv_pkg::stat_t  stat,
    output lpv_pkg::cmd_t   cmd
);

    lpv_pkg::state_t          state_reg, state_next;
    logic [lpv_pkg::GW-1:0]   grp_reg, grp_next;
    logic [lpv_pkg::JW-1:0]   term_reg, term_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpv_pkg::ST_IDLE;
            grp_reg   <= '0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
            term_reg  <= term_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        grp_next     = grp_reg;
        term_next    = term_reg;
        cmd.msel     = lpv_pkg::M_NONE;
        cmd.post     = lpv_pkg::P_NONE;
        cmd.grp      = grp_reg;
        cmd.term     = term_reg;
        cmd.in_load  = 1'b0;
        cmd.clr_sum  = 1'b0;
        cmd.out_load = 1'b0;
        cmd.commit   = 1'b0;
        in_stall     = (state_reg != lpv_pkg::ST_IDLE);

        case (state_reg)
            lpv_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    cmd.clr_sum = 1'b1;
                    grp_next    = '0;
                    term_next   = '0;
                    state_next  = lpv_pkg::ST_EFF;
                end
            end
            lpv_pkg::ST_EFF:
            begin
                cmd.msel   = lpv_pkg::M_EFF;
                cmd.post   = lpv_pkg::P_EFF;
                state_next = lpv_pkg::ST_GAP;
            end
            lpv_pkg::ST_GAP:
            begin
                // fold the previous term of this row while the coefficient settles
                if (term_reg != '0)
                begin
                    cmd.post = lpv_pkg::P_FOLD20;
                end
                state_next = lpv_pkg::ST_XLO;
            end
            lpv_pkg::ST_XLO:
            begin
                cmd.msel   = lpv_pkg::M_XLO;
                cmd.post   = lpv_pkg::P_PLOAD;
                state_next = lpv_pkg::ST_XHI;
            end
            lpv_pkg::ST_XHI:
            begin
                cmd.msel = lpv_pkg::M_XHI;
                cmd.post = lpv_pkg::P_PADD16;
                if (term_reg == lpv_pkg::JW'(lpv_pkg::STATE_COUNT - 1))
                begin
                    state_next = lpv_pkg::ST_FOLD;
                end
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = lpv_pkg::ST_EFF;
                end
            end
            lpv_pkg::ST_FOLD:
            begin
                cmd.post   = lpv_pkg::P_FOLD20;
                state_next = lpv_pkg::ST_GAIN;
            end
            lpv_pkg::ST_GAIN:
            begin
                cmd.msel   = lpv_pkg::M_GAIN;
                cmd.post   = lpv_pkg::P_GAIN;
                state_next = lpv_pkg::ST_SETTLE;
            end
            lpv_pkg::ST_SETTLE:
            begin
                state_next = (grp_reg == '0) ? lpv_pkg::ST_OUT : lpv_pkg::ST_DLO;
            end
            lpv_pkg::ST_OUT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clr_sum  = 1'b1;
                    grp_next     = lpv_pkg::GW'(1);
                    term_next    = '0;
                    state_next   = lpv_pkg::ST_EFF;
                end
            end
            lpv_pkg::ST_DLO:
            begin
                cmd.msel   = lpv_pkg::M_DLO;
                cmd.post   = lpv_pkg::P_PLOAD;
                state_next = lpv_pkg::ST_DHI;
            end
            lpv_pkg::ST_DHI:
            begin
                cmd.msel   = lpv_pkg::M_DHI;
                cmd.post   = lpv_pkg::P_PADD24;
                state_next = lpv_pkg::ST_DGAP;
            end
            lpv_pkg::ST_DGAP:
            begin
                state_next = lpv_pkg::ST_DFOLD;
            end
            lpv_pkg::ST_DFOLD:
            begin
                cmd.post    = lpv_pkg::P_FOLD16;
                cmd.clr_sum = 1'b1;
                if (grp_reg == lpv_pkg::GW'(lpv_pkg::STATE_COUNT))
                begin
                    state_next = lpv_pkg::ST_WRAP;
                end
                else
                begin
                    grp_next   = grp_reg + 1'b1;
                    term_next  = '0;
                    state_next = lpv_pkg::ST_EFF;
                end
            end
            lpv_pkg::ST_WRAP:
            begin
                state_next = lpv_pkg::ST_COMMIT;
            end
            lpv_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = lpv_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lpv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/lpv_datapath.sv
// Datapath of the Euler step unit: one shared signed multiplier, product
// accumulator, row sum, state and output registers. Depends on lpv_pkg.
module lpv_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lpv_pkg::cmd_t                      cmd,
    output lpv_pkg::stat_t                     stat,
    input  logic signed [lpv_pkg::IN_W-1:0]    torque,
    input  logic [lpv_pkg::IN_W-1:0]           speed,
    input  logic [lpv_pkg::CFG_DW-1:0]         a_bias_words,
    input  logic [lpv_pkg::CFG_DW-1:0]         a_speed_words,
    input  logic [lpv_pkg::GAIN_W-1:0]         drive_gain_words,
    input  logic [lpv_pkg::CFG_DW-1:0]         c_words,
    input  logic [lpv_pkg::TS_W-1:0]           time_step,
    output logic signed [lpv_pkg::X_W-1:0]     wheel_angle,
    output logic                               out_valid,
    input  logic                               out_stall
);

    logic signed [lpv_pkg::IN_W-1:0]   tq_reg, tq_next;
    logic [lpv_pkg::IN_W-1:0]          v_reg, v_next;
    logic signed [lpv_pkg::EFF_W-1:0]  eff_reg, eff_next;
    logic signed [lpv_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [lpv_pkg::PACC_W-1:0] pacc_reg, pacc_next;
    logic signed [lpv_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic signed [lpv_pkg::X_W-1:0]    out_reg, out_next;
    logic                              out_valid_reg, out_valid_next;
    lpv_pkg::cmd_t                     cmd_q_reg, cmd_q_next;
    logic signed [lpv_pkg::X_W-1:0]    state_reg [lpv_pkg::STATE_COUNT];
    logic signed [lpv_pkg::X_W-1:0]    state_next [lpv_pkg::STATE_COUNT];
    logic signed [lpv_pkg::X_W-1:0]    xnew_reg [lpv_pkg::STATE_COUNT];
    logic signed [lpv_pkg::X_W-1:0]    xnew_next [lpv_pkg::STATE_COUNT];

    logic signed [lpv_pkg::MA_W-1:0]       op_a;
    logic signed [lpv_pkg::MB_W-1:0]       op_b;
    logic signed [lpv_pkg::COEF_WIDTH-1:0] spd_coef;
    logic signed [lpv_pkg::COEF_WIDTH-1:0] gain_coef;
    logic signed [lpv_pkg::COEF_WIDTH-1:0] bias_coef;
    logic signed [lpv_pkg::X_W-1:0]        x_sel;
    logic signed [lpv_pkg::PACC_W-1:0]     prod_ext;
    logic signed [lpv_pkg::XSUM_W-1:0]     xsum;
    logic [lpv_pkg::JW-1:0]                row_idx;

    // Multiply stage: operand selection
    always_comb
    begin
        if (cmd.grp == '0)
        begin
            spd_coef  = lpv_pkg::coef_field(c_words, lpv_pkg::STATE_COUNT + int'(cmd.term));
            gain_coef = lpv_pkg::coef_field(64'(drive_gain_words), lpv_pkg::STATE_COUNT);
        end
        else
        begin
            spd_coef  = lpv_pkg::coef_field(a_speed_words,
                            (int'(cmd.grp) - 1) * lpv_pkg::STATE_COUNT + int'(cmd.term));
            gain_coef = lpv_pkg::coef_field(64'(drive_gain_words), int'(cmd.grp) - 1);
        end
        x_sel = state_reg[cmd.term];

        op_a = '0;
        op_b = '0;
        case (cmd.msel)
            lpv_pkg::M_EFF:
            begin
                op_a = lpv_pkg::MA_W'(spd_coef);
                op_b = $signed({2'b00, v_reg});
            end
            lpv_pkg::M_XLO:
            begin
                op_a = eff_reg;
                op_b = $signed({2'b00, x_sel[lpv_pkg::X_SPLIT-1:0]});
            end
            lpv_pkg::M_XHI:
            begin
                op_a = eff_reg;
                op_b = {{(lpv_pkg::MB_W - (lpv_pkg::X_W - lpv_pkg::X_SPLIT)){x_sel[lpv_pkg::X_W-1]}},
                        x_sel[lpv_pkg::X_W-1:lpv_pkg::X_SPLIT]};
            end
            lpv_pkg::M_GAIN:
            begin
                op_a = lpv_pkg::MA_W'(gain_coef);
                op_b = lpv_pkg::MB_W'(tq_reg);
            end
            lpv_pkg::M_DLO:
            begin
                op_a = $signed({{(lpv_pkg::MA_W - lpv_pkg::DX_SPLIT){1'b0}},
                                sum_reg[lpv_pkg::DX_SPLIT-1:0]});
                op_b = $signed({2'b00, time_step});
            end
            lpv_pkg::M_DHI:
            begin
                op_a = {{(lpv_pkg::MA_W - (lpv_pkg::SUM_W - lpv_pkg::DX_SPLIT))
                         {sum_reg[lpv_pkg::SUM_W-1]}},
                        sum_reg[lpv_pkg::SUM_W-1:lpv_pkg::DX_SPLIT]};
                op_b = $signed({2'b00, time_step});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_next  = op_a * op_b;
        cmd_q_next = cmd;
    end

    // Accumulate stage: act on the registered product
    always_comb
    begin
        if (cmd_q_reg.grp == '0)
        begin
            bias_coef = lpv_pkg::coef_field(c_words, int'(cmd_q_reg.term));
        end
        else
        begin
            bias_coef = lpv_pkg::coef_field(a_bias_words,
                            (int'(cmd_q_reg.grp) - 1) * lpv_pkg::STATE_COUNT
                            + int'(cmd_q_reg.term));
        end
        row_idx  = lpv_pkg::JW'(cmd_q_reg.grp - 1'b1);
        prod_ext = lpv_pkg::PACC_W'(prod_reg);
        xsum     = lpv_pkg::XSUM_W'(state_reg[row_idx])
                 + lpv_pkg::XSUM_W'(pacc_reg >>> lpv_pkg::DT_FRAC);

        eff_next  = eff_reg;
        pacc_next = pacc_reg;
        sum_next  = sum_reg;
        xnew_next = xnew_reg;

        case (cmd_q_reg.post)
            lpv_pkg::P_EFF:
            begin
                eff_next = prod_reg[lpv_pkg::EFF_W-1:0]
                         + (lpv_pkg::EFF_W'(bias_coef) <<< lpv_pkg::IN_FRAC);
            end
            lpv_pkg::P_PLOAD:
            begin
                pacc_next = prod_ext;
            end
            lpv_pkg::P_PADD16:
            begin
                pacc_next = pacc_reg + (prod_ext <<< lpv_pkg::X_SPLIT);
            end
            lpv_pkg::P_PADD24:
            begin
                pacc_next = pacc_reg + (prod_ext <<< lpv_pkg::DX_SPLIT);
            end
            lpv_pkg::P_FOLD20:
            begin
                sum_next = sum_reg + lpv_pkg::SUM_W'(pacc_reg >>> lpv_pkg::EFF_FRAC);
            end
            lpv_pkg::P_GAIN:
            begin
                sum_next = sum_reg + lpv_pkg::SUM_W'(prod_reg >>> lpv_pkg::GAIN_SHIFT);
            end
            lpv_pkg::P_FOLD16:
            begin
                xnew_next[row_idx] = lpv_pkg::sat_x(xsum);
            end
            default:
            begin
                eff_next = eff_reg;
            end
        endcase

        if (cmd.clr_sum)
        begin
            sum_next = '0;
        end
    end

    // Input capture, commit and output register
    always_comb
    begin
        tq_next = tq_reg;
        v_next  = v_reg;
        if (cmd.in_load)
        begin
            tq_next = torque;
            v_next  = (speed < lpv_pkg::MIN_SPEED) ? lpv_pkg::MIN_SPEED : speed;
        end

        state_next = state_reg;
        if (cmd.commit)
        begin
            state_next = xnew_reg;
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_next       = lpv_pkg::sat_x(lpv_pkg::XSUM_W'(sum_reg));
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_q_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < lpv_pkg::STATE_COUNT; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else
        begin
            cmd_q_reg     <= cmd_q_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tq_reg   <= tq_next;
        v_reg    <= v_next;
        eff_reg  <= eff_next;
        prod_reg <= prod_next;
        pacc_reg <= pacc_next;
        sum_reg  <= sum_next;
        out_reg  <= out_next;
        xnew_reg <= xnew_next;
    end

    assign wheel_angle   = out_reg;
    assign out_valid     = out_valid_reg;
    assign stat.out_free = !out_valid_reg || !out_stall;

endmodule

>>> sv/lpv_state_space_euler_step_unit.sv
// Top level of the speed-scheduled state-space Euler step unit: configuration
// registers on the APB-style port, sequencer and datapath. Depends on lpv_pkg,
// lpv_ctrl and lpv_datapath.
//
// Each input word (torque, speed) yields one wheel_angle word, computed from the
// state held before the update; the two-element state then advances by one
// forward Euler step. Speed is raised to 5.0 when below it. All arithmetic runs
// through one shared signed multiplier, at most one product per cycle while the
// sequencer is not held: a new word is not accepted until the last one's state
// update is committed, and the output is loaded before the state rows are done.
// The finished result waits in an output register; the next word is taken while
// it waits, and the block only holds in mid-sequence if a second result is ready
// before the first is taken. Configuration registers sit at byte address 8*i
// (64-bit data) and must be written only while the block is idle.
module lpv_state_space_euler_step_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpv_pkg::CFG_AW-1:0]          paddr,
    input  logic [lpv_pkg::CFG_DW-1:0]          pwdata,
    output logic [lpv_pkg::CFG_DW-1:0]          prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [lpv_pkg::IN_W-1:0]     torque,
    input  logic [lpv_pkg::IN_W-1:0]            speed,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lpv_pkg::X_W-1:0]      wheel_angle
);

    logic [lpv_pkg::CFG_DW-1:0] a_bias_reg, a_bias_next;
    logic [lpv_pkg::CFG_DW-1:0] a_speed_reg, a_speed_next;
    logic [lpv_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic [lpv_pkg::CFG_DW-1:0] c_words_reg, c_words_next;
    logic [lpv_pkg::TS_W-1:0]   time_step_reg, time_step_next;
    logic [lpv_pkg::CFG_IW-1:0] reg_idx;
    logic                       wr_en;

    lpv_pkg::cmd_t  cmd;
    lpv_pkg::stat_t stat;

    assign reg_idx = paddr[lpv_pkg::CFG_AW-1:lpv_pkg::CFG_AW-lpv_pkg::CFG_IW];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        a_bias_next    = a_bias_reg;
        a_speed_next   = a_speed_reg;
        gain_next      = gain_reg;
        c_words_next   = c_words_reg;
        time_step_next = time_step_reg;
        if (wr_en)
        begin
            case (reg_idx)
                lpv_pkg::REG_A_BIAS:     a_bias_next    = pwdata;
                lpv_pkg::REG_A_SPEED:    a_speed_next   = pwdata;
                lpv_pkg::REG_DRIVE_GAIN: gain_next      = pwdata[lpv_pkg::GAIN_W-1:0];
                lpv_pkg::REG_C_WORDS:    c_words_next   = pwdata;
                lpv_pkg::REG_TIME_STEP:  time_step_next = pwdata[lpv_pkg::TS_W-1:0];
                default:                 a_bias_next    = a_bias_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lpv_pkg::REG_A_BIAS:     prdata = a_bias_reg;
            lpv_pkg::REG_A_SPEED:    prdata = a_speed_reg;
            lpv_pkg::REG_DRIVE_GAIN: prdata = lpv_pkg::CFG_DW'(gain_reg);
            lpv_pkg::REG_C_WORDS:    prdata = c_words_reg;
            lpv_pkg::REG_TIME_STEP:  prdata = lpv_pkg::CFG_DW'(time_step_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_bias_reg    <= '0;
            a_speed_reg   <= '0;
            gain_reg      <= '0;
            c_words_reg   <= '0;
            time_step_reg <= lpv_pkg::TIME_STEP_RESET;
        end
        else
        begin
            a_bias_reg    <= a_bias_next;
            a_speed_reg   <= a_speed_next;
            gain_reg      <= gain_next;
            c_words_reg   <= c_words_next;
            time_step_reg <= time_step_next;
        end
    end

    lpv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpv_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .torque           (torque),
        .speed            (speed),
        .a_bias_words     (a_bias_reg),
        .a_speed_words    (a_speed_reg),
        .drive_gain_words (gain_reg),
        .c_words          (c_words_reg),
        .time_step        (time_step_reg),
        .wheel_angle      (wheel_angle),
        .out_valid        (out_valid),
        .out_stall        (out_stall)
    );

endmodule

>>> verif/tb.sv
// Self-checking bench for lpv_state_space_euler_step_unit: a directed table, then random
// phases with random register settings, handshake gaps and output hold-offs.
// Depends on lpv_pkg and the RTL of the unit; the predictor below keeps its own plant state.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RESET_CYCLES    = 9;
    localparam int     SETTLE_CYCLES   = 60;
    localparam int     HOLD_CYCLES     = 400;
    localparam int     RANDOM_PHASES   = 12;
    localparam int     WORDS_PER_PHASE = 161;
    localparam int     PRINT_LIMIT     = 40;
    localparam longint CYCLE_LIMIT     = 1500000;
    localparam longint X_HI            = 64'sd2147483647;
    localparam longint X_LO            = -64'sd2147483648;

    // Addresses past the register list
    localparam logic [lpv_pkg::CFG_IW-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [lpv_pkg::CFG_IW-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {CS_SMALL, CS_FULL, CS_MAX, CS_MIN, CS_ZERO, CS_ONES} coef_style_t;

    typedef struct {
        bit                         is_cfg;
        logic [lpv_pkg::CFG_IW-1:0] idx;
        logic [63:0]                value;
        logic [lpv_pkg::IN_W-1:0]   tq;
        logic [lpv_pkg::IN_W-1:0]   sp;
        bit                         known;
        logic [lpv_pkg::X_W-1:0]    angle;
    } plan_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [lpv_pkg::CFG_AW-1:0]         paddr;
    logic [lpv_pkg::CFG_DW-1:0]         pwdata;
    logic [lpv_pkg::CFG_DW-1:0]         prdata;
    logic                               pready;
    logic                               in_valid;
    logic                               in_stall;
    logic signed [lpv_pkg::IN_W-1:0]    torque;
    logic [lpv_pkg::IN_W-1:0]           speed;
    logic                               out_valid;
    logic                               out_stall;
    logic signed [lpv_pkg::X_W-1:0]     wheel_angle;

    // Predictor copy of the registers and the plant state
    logic [63:0]                m_a_bias;
    logic [63:0]                m_a_speed;
    logic [63:0]                m_c;
    logic [lpv_pkg::GAIN_W-1:0] m_gain;
    logic [lpv_pkg::TS_W-1:0]   m_dt;
    longint                     plant_x[lpv_pkg::STATE_COUNT];

    logic [lpv_pkg::X_W-1:0] angle_due[$];
    plan_row_t               directed_rows[$];

    int     errors;
    int     words_sent;
    int     angles_seen;
    int     reg_writes;
    int     holdoffs;
    longint cycles;
    bit     tx_calm;
    bit     rx_calm;
    bit     hold_req;

    lpv_state_space_euler_step_unit dut (.*);

    always #6 clk = ~clk;

    task automatic note_error(input string what);
        if (errors < PRINT_LIMIT)
        begin
            $display("tb: mismatch at %0t: %s", $time, what);
        end
        errors++;
    endtask

    function automatic longint coef(input logic [63:0] w, input int k);
        logic signed [lpv_pkg::COEF_WIDTH-1:0] f;
        f = w[k*lpv_pkg::COEF_WIDTH +: lpv_pkg::COEF_WIDTH];
        return longint'(f);
    endfunction

    function automatic longint clamp_x(input longint v);
        if (v > X_HI)
        begin
            return X_HI;
        end
        if (v < X_LO)
        begin
            return X_LO;
        end
        return v;
    endfunction

    // Angle from the old state, then one forward Euler step of the plant
    function automatic logic [lpv_pkg::X_W-1:0] advance_plant(
        input logic signed [lpv_pkg::IN_W-1:0] tq,
        input logic [lpv_pkg::IN_W-1:0]        sp);
        longint t;
        longint v;
        longint dt;
        longint eff;
        longint y;
        longint acc;
        longint dx[lpv_pkg::STATE_COUNT];
        t  = longint'(tq);
        v  = longint'(sp);
        dt = longint'(m_dt);
        if (v < longint'(lpv_pkg::MIN_SPEED))
        begin
            v = longint'(lpv_pkg::MIN_SPEED);
        end
        y = 0;
        for (int i = 0; i < lpv_pkg::STATE_COUNT; i++)
        begin
            eff = coef(m_c, i) * (longint'(1) << lpv_pkg::IN_FRAC)
                + coef(m_c, lpv_pkg::STATE_COUNT + i) * v;
            y += (eff * plant_x[i]) >>> lpv_pkg::EFF_FRAC;
        end
        y += (coef(64'(m_gain), lpv_pkg::STATE_COUNT) * t) >>> lpv_pkg::GAIN_SHIFT;
        for (int i = 0; i < lpv_pkg::STATE_COUNT; i++)
        begin
            acc = 0;
            for (int j = 0; j < lpv_pkg::STATE_COUNT; j++)
            begin
                eff = coef(m_a_bias, i*lpv_pkg::STATE_COUNT + j) * (longint'(1) << lpv_pkg::IN_FRAC)
                    + coef(m_a_speed, i*lpv_pkg::STATE_COUNT + j) * v;
                acc += (eff * plant_x[j]) >>> lpv_pkg::EFF_FRAC;
            end
            acc += (coef(64'(m_gain), i) * t) >>> lpv_pkg::GAIN_SHIFT;
            dx[i] = acc;
        end
        for (int i = 0; i < lpv_pkg::STATE_COUNT; i++)
        begin
            plant_x[i] = clamp_x(plant_x[i] + ((dx[i] * dt) >>> lpv_pkg::DT_FRAC));
        end
        y = clamp_x(y);
        return y[lpv_pkg::X_W-1:0];
    endfunction

    function automatic logic [63:0] model_reg(input logic [lpv_pkg::CFG_IW-1:0] idx);
        case (idx)
            lpv_pkg::REG_A_BIAS:     return m_a_bias;
            lpv_pkg::REG_A_SPEED:    return m_a_speed;
            lpv_pkg::REG_DRIVE_GAIN: return 64'(m_gain);
            lpv_pkg::REG_C_WORDS:    return m_c;
            lpv_pkg::REG_TIME_STEP:  return 64'(m_dt);
            default:                 return '0;
        endcase
    endfunction

    function automatic plan_row_t row_cfg(input logic [lpv_pkg::CFG_IW-1:0] idx,
                                          input logic [63:0] value);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1;
        r.idx    = idx;
        r.value  = value;
        return r;
    endfunction

    function automatic plan_row_t row_word(input logic [lpv_pkg::IN_W-1:0] tq,
                                           input logic [lpv_pkg::IN_W-1:0] sp);
        plan_row_t r;
        r = '{default: '0};
        r.tq = tq;
        r.sp = sp;
        return r;
    endfunction

    function automatic plan_row_t row_known(input logic [lpv_pkg::IN_W-1:0] tq,
                                            input logic [lpv_pkg::IN_W-1:0] sp,
                                            input logic [lpv_pkg::X_W-1:0] angle);
        plan_row_t r;
        r       = row_word(tq, sp);
        r.known = 1;
        r.angle = angle;
        return r;
    endfunction

    function automatic logic [63:0] pick_coefs();
        logic [63:0]                           w;
        logic signed [lpv_pkg::COEF_WIDTH-1:0] f;
        coef_style_t                           style;
        int                                    r;
        r     = $urandom_range(0, 9);
        style = (r < 5) ? CS_SMALL : coef_style_t'(r - 4);
        for (int k = 0; k < 64 / lpv_pkg::COEF_WIDTH; k++)
        begin
            case (style)
                CS_SMALL: f = lpv_pkg::COEF_WIDTH'($urandom_range(0, 2047) - 1024);
                CS_FULL:  f = lpv_pkg::COEF_WIDTH'($urandom);
                CS_MAX:   f = 16'h7FFF;
                CS_MIN:   f = 16'h8000;
                CS_ZERO:  f = '0;
                default:  f = '1;
            endcase
            w[k*lpv_pkg::COEF_WIDTH +: lpv_pkg::COEF_WIDTH] = f;
        end
        return w;
    endfunction

    // Random bits above the field are meant to be dropped by the register
    function automatic logic [63:0] pick_time_step();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       w[lpv_pkg::TS_W-1:0] = '0;
            1:       w[lpv_pkg::TS_W-1:0] = '1;
            2:       w[lpv_pkg::TS_W-1:0] = lpv_pkg::TIME_STEP_RESET;
            3:       w[lpv_pkg::TS_W-1:0] = lpv_pkg::TS_W'($urandom);
            default: w[lpv_pkg::TS_W-1:0] = lpv_pkg::TS_W'($urandom_range(1, 4000));
        endcase
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [lpv_pkg::IN_W-1:0] pick_speed();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)
        begin
            return lpv_pkg::IN_W'($urandom_range(0, lpv_pkg::MIN_SPEED - 1));
        end
        if (r == 4)
        begin
            return lpv_pkg::MIN_SPEED;
        end
        return lpv_pkg::IN_W'($urandom);
    endfunction

    task automatic read_reg(input logic [lpv_pkg::CFG_IW-1:0] idx, output logic [63:0] value);
        @(negedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 0;
        paddr   <= lpv_pkg::CFG_AW'(idx) << 3;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        value = prdata;
        @(negedge clk);
        psel    <= 0;
        penable <= 0;
    endtask

    task automatic write_reg(input logic [lpv_pkg::CFG_IW-1:0] idx, input logic [63:0] value);
        logic [63:0] back;
        @(negedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= lpv_pkg::CFG_AW'(idx) << 3;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        reg_writes++;
        case (idx)
            lpv_pkg::REG_A_BIAS:     m_a_bias  = value;
            lpv_pkg::REG_A_SPEED:    m_a_speed = value;
            lpv_pkg::REG_DRIVE_GAIN: m_gain    = value[lpv_pkg::GAIN_W-1:0];
            lpv_pkg::REG_C_WORDS:    m_c       = value;
            lpv_pkg::REG_TIME_STEP:  m_dt      = value[lpv_pkg::TS_W-1:0];
            default:                 return;
        endcase
        read_reg(idx, back);
        if (back !== model_reg(idx))
        begin
            note_error($sformatf("register %0d reads %h, wrote %h", idx, back, model_reg(idx)));
        end
    endtask

    // Offer one word, hold it until taken, then log its expected angle
    task automatic send_word(input logic [lpv_pkg::IN_W-1:0] tq,
                             input logic [lpv_pkg::IN_W-1:0] sp,
                             input bit known, input logic [lpv_pkg::X_W-1:0] angle);
        logic [lpv_pkg::X_W-1:0] predicted;
        int                      gap;
        @(negedge clk);
        in_valid <= 1;
        torque   <= tq;
        speed    <= sp;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted = advance_plant(tq, sp);
        angle_due.push_back(known ? angle : predicted);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Wait for every angle, then let the state update finish
    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (angle_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        logic [lpv_pkg::X_W-1:0] due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (angle_due.size() == 0)
            begin
                note_error($sformatf("wheel_angle %h with nothing outstanding", wheel_angle));
            end
            else
            begin
                due = angle_due.pop_front();
                angles_seen++;
                if (wheel_angle !== due)
                begin
                    note_error($sformatf("wheel_angle %h, predicted %h (word %0d)",
                                         wheel_angle, due, angles_seen));
                end
            end
        end
    end

    // Output side: random stalls, or one long hold-off on request
    initial
    begin
        int run;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1;
                holdoffs++;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 0;
            end
            else if (rx_calm || $urandom_range(0, 3) != 0)
            begin
                out_stall <= 0;
            end
            else
            begin
                run = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
                out_stall <= 1;
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: timeout after %0d cycles, %0d angles outstanding", cycles, angle_due.size());
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        clk      = 0;
        rst_n    = 0;
        psel     = 0;
        penable  = 0;
        pwrite   = 0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 0;
        torque   = '0;
        speed    = '0;
        tx_calm  = 0;
        rx_calm  = 0;
        hold_req = 0;
        m_a_bias  = '0;
        m_a_speed = '0;
        m_c       = '0;
        m_gain    = '0;
        m_dt      = lpv_pkg::TIME_STEP_RESET;
        foreach (plant_x[i])
        begin
            plant_x[i] = 0;
        end

        // Reset values: no gains, so every angle is zero
        directed_rows.push_back(row_known(16'h0000, 16'h0000, 32'h0000_0000));
        directed_rows.push_back(row_known(16'h8000, 16'hFFFF, 32'h0000_0000));
        directed_rows.push_back(row_known(16'h7FFF, 16'd1279, 32'h0000_0000));
        // Feedthrough of 1.0 only; bits above the gain register are junk
        directed_rows.push_back(row_cfg(lpv_pkg::REG_DRIVE_GAIN, 64'hABCD_1000_0000_0000));
        directed_rows.push_back(row_known(16'h7FFF, 16'd1280, 32'h007F_FF00));
        directed_rows.push_back(row_known(16'h8000, 16'h0000, 32'hFF80_0000));
        directed_rows.push_back(row_known(16'h0001, 16'd500,  32'h0000_0100));
        directed_rows.push_back(row_known(16'hFFFF, 16'd600,  32'hFFFF_FF00));
        // Writes past the register list change nothing
        directed_rows.push_back(row_cfg(REG_SPARE_LO, '1));
        directed_rows.push_back(row_cfg(REG_SPARE_HI, '1));
        directed_rows.push_back(row_known(16'h0100, 16'd2000, 32'h0001_0000));
        // Full plant, widest time step, hard drive toward saturation
        directed_rows.push_back(row_cfg(lpv_pkg::REG_A_BIAS,     64'h7FFF_8000_0800_F000));
        directed_rows.push_back(row_cfg(lpv_pkg::REG_A_SPEED,    64'h0001_FFFF_0002_FFFE));
        directed_rows.push_back(row_cfg(lpv_pkg::REG_C_WORDS,    64'h0400_1000_0010_FFF0));
        directed_rows.push_back(row_cfg(lpv_pkg::REG_DRIVE_GAIN, 64'hFFFF_7FFF_8000_1000));
        directed_rows.push_back(row_cfg(lpv_pkg::REG_TIME_STEP,  64'h1234_0000_0000_FFFF));
        directed_rows.push_back(row_word(16'h7FFF, 16'hFFFF));
        directed_rows.push_back(row_word(16'h7FFF, 16'hFFFF));
        directed_rows.push_back(row_word(16'h7FFF, 16'hFFFF));
        directed_rows.push_back(row_word(16'h8000, 16'h0000));
        directed_rows.push_back(row_word(16'h1234, 16'd1279));
        directed_rows.push_back(row_word(16'h0000, 16'd1280));
        directed_rows.push_back(row_word(16'hFFFF, 16'd1281));
        // Zero time step: state must hold
        directed_rows.push_back(row_cfg(lpv_pkg::REG_TIME_STEP, 64'h0));
        directed_rows.push_back(row_word(16'h7FFF, 16'h8000));
        directed_rows.push_back(row_word(16'h8000, 16'h4000));
        // Extreme output weights and speed terms
        directed_rows.push_back(row_cfg(lpv_pkg::REG_C_WORDS,   64'h7FFF_8000_7FFF_8000));
        directed_rows.push_back(row_cfg(lpv_pkg::REG_A_SPEED,   64'h8000_8000_8000_8000));
        directed_rows.push_back(row_cfg(lpv_pkg::REG_TIME_STEP, 64'hFFFF));
        directed_rows.push_back(row_word(16'h7FFF, 16'hFFFF));
        directed_rows.push_back(row_word(16'h8000, 16'hFFFF));
        directed_rows.push_back(row_word(16'h5555, 16'hAAAA));
        directed_rows.push_back(row_word(16'hAAAA, 16'h5555));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        foreach (directed_rows[n])
        begin
            if (directed_rows[n].is_cfg)
            begin
                drain();
                write_reg(directed_rows[n].idx, directed_rows[n].value);
            end
            else
            begin
                send_word(directed_rows[n].tq, directed_rows[n].sp,
                          directed_rows[n].known, directed_rows[n].angle);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            if (p == 0 || $urandom_range(0, 2) != 0)
            begin
                write_reg(lpv_pkg::REG_A_BIAS, pick_coefs());
            end
            if (p == 0 || $urandom_range(0, 2) != 0)
            begin
                write_reg(lpv_pkg::REG_A_SPEED, pick_coefs());
            end
            if (p == 0 || $urandom_range(0, 2) != 0)
            begin
                write_reg(lpv_pkg::REG_DRIVE_GAIN, pick_coefs());
            end
            if (p == 0 || $urandom_range(0, 2) != 0)
            begin
                write_reg(lpv_pkg::REG_C_WORDS, pick_coefs());
            end
            if (p == 0 || $urandom_range(0, 2) != 0)
            begin
                write_reg(lpv_pkg::REG_TIME_STEP, pick_time_step());
            end
            // Phase 3 backs the block up behind a long output hold-off
            tx_calm  = (p == 3 || p == 6);
            rx_calm  = (p == 6);
            hold_req = (p == 3);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                send_word(lpv_pkg::IN_W'($urandom), pick_speed(), 1'b0, '0);
                if (p == 8 && n == WORDS_PER_PHASE / 2)
                begin
                    drain();
                end
            end
        end
        tx_calm = 0;
        rx_calm = 0;
        drain();

        $display("tb: %0d words sent, %0d angles checked, %0d register writes",
                 words_sent, angles_seen, reg_writes);
        $display("tb: %0d long output hold-offs; low-speed clamp, zero and full time step covered",
                 holdoffs);
        if (errors == 0 && angle_due.size() == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
